// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL; NO_ASSERTIONS compiles them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every rising clock edge outside reset.
`define BSCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked in the same cycle.
`define BSCD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BSCD_ASSERT(label, prop, msg)
`define BSCD_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

// ===== rtl/bscd_pkg.sv =====
// Types, constants and the CRC-32 byte update for the chunk deframer.
`default_nettype none
package bscd_pkg;

  localparam int DataW   = 8;
  localparam int OffW    = 12;
  localparam int LenW    = 31;
  localparam int CrcW    = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 3;

  localparam int BlockBytesDef = 4096;
  localparam int MaxHeaderDef  = 1024;

  localparam logic [LenW-1:0]   HdrMin  = LenW'(4);
  localparam logic [CrcW-1:0]   CrcPoly = 32'hEDB8_8320;
  localparam logic [CountW-1:0] LastPrefixByte = 3'd7;
  localparam logic [CountW-1:0] LengthBytes    = 3'd4;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhPrefix  = 2'd1,
    PhPayload = 2'd2
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StCorrupt = 2'd1,
    StCrcFail = 2'd2
  } status_e;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic [OffW-1:0]  block_offset;
    logic             chunk_start;
    logic             header_mode;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] payload_byte;
    logic             payload_valid;
    logic             last;
    status_e          status;
    logic [LenW-1:0]  chunk_length;
  } result_t;

  // Reflected CRC-32, one byte folded in bit by bit.
  function automatic logic [CrcW-1:0] crc32_byte(input logic [CrcW-1:0] crc,
                                                 input logic [DataW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ CrcW'(b);
    for (int i = 0; i < DataW; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bscd_in_if.sv =====
// Input channel of the deframer: one raw file byte and its tags per transaction.
`default_nettype none
interface bscd_in_if;
  logic                      valid;
  logic                      ready;
  logic [bscd_pkg::DataW-1:0] data_byte;
  logic [bscd_pkg::OffW-1:0]  block_offset;
  logic                      chunk_start;
  logic                      header_mode;

  modport source (output valid, output data_byte, output block_offset,
                  output chunk_start, output header_mode, input ready);
  modport sink   (input valid, input data_byte, input block_offset,
                  input chunk_start, input header_mode, output ready);
endinterface
`default_nettype wire

// ===== rtl/bscd_out_if.sv =====
// Output channel of the deframer: one payload byte or chunk end per transaction.
`default_nettype none
interface bscd_out_if;
  logic                         valid;
  logic                         ready;
  logic [bscd_pkg::DataW-1:0]   payload_byte;
  logic                         payload_valid;
  logic                         last;
  logic [bscd_pkg::StatusW-1:0] status;
  logic [bscd_pkg::LenW-1:0]    chunk_length;

  modport source (output valid, output payload_byte, output payload_valid,
                  output last, output status, output chunk_length, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input last, input status, input chunk_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/bscd_in_reg.sv =====
// Input register: captures one transaction and holds it until the engine takes it.
`default_nettype none
module bscd_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire bscd_pkg::item_t item_i,
  output logic               item_valid_o,
  output bscd_pkg::item_t    item_o,
  input  wire logic          item_take_i
);
  import bscd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign ready_o = !valid_q || item_take_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (item_take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
endmodule
`default_nettype wire

// ===== rtl/bscd_engine.sv =====
// Chunk state machine, CRC-32 and result register of the deframer.
`default_nettype none
`include "assert_macros.svh"
module bscd_engine #(
  parameter int BLOCK_BYTES = bscd_pkg::BlockBytesDef,
  parameter int MAX_HEADER  = bscd_pkg::MaxHeaderDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  input  wire bscd_pkg::item_t item_i,
  output logic                 item_take_o,
  output logic                 res_valid_o,
  output bscd_pkg::result_t    res_o,
  input  wire logic            res_ready_i
);
  import bscd_pkg::*;

  localparam int OffSpan  = 1 << OffW;
  localparam int NumMults = (OffSpan + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam logic [LenW-1:0] MaxHdr = LenW'(MAX_HEADER);

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic              hdr_q, hdr_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [CrcW-1:0]   exp_q, exp_d;
  logic [CrcW-1:0]   crc_q, crc_d;
  logic [LenW-1:0]   left_q, left_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  // Chunk state as seen after a chunk start has been applied.
  phase_e            eff_phase;
  logic [CountW-1:0] eff_count;
  logic              eff_hdr;
  logic [LenW-1:0]   eff_len;
  logic [CrcW-1:0]   eff_exp;
  logic [CrcW-1:0]   eff_crc;
  logic [LenW-1:0]   eff_left;

  logic              skip;
  logic              prefix_end;
  logic              prefix_emit;
  logic              len_bad;
  logic [LenW-1:0]   adj_len;
  logic [CrcW-1:0]   exp_next;
  logic [CrcW-1:0]   crc_next;
  logic [LenW-1:0]   left_next;
  logic              produces;
  logic              go;

  // A byte is a block prefix byte when its offset is a multiple of the block size.
  always_comb begin
    skip = 1'b0;
    for (int k = 0; k < NumMults; k++) begin
      if (int'(item_i.block_offset) == k * BLOCK_BYTES) begin
        skip = 1'b1;
      end
    end
  end

  always_comb begin
    if (item_i.chunk_start) begin
      eff_phase = PhPrefix;
      eff_count = '0;
      eff_hdr   = item_i.header_mode;
      eff_len   = '0;
      eff_exp   = '0;
      eff_crc   = '1;
      eff_left  = '0;
    end else begin
      eff_phase = phase_q;
      eff_count = count_q;
      eff_hdr   = hdr_q;
      eff_len   = len_q;
      eff_exp   = exp_q;
      eff_crc   = crc_q;
      eff_left  = left_q;
    end
  end

  assign prefix_end = (eff_count == LastPrefixByte);
  assign exp_next   = {eff_exp[CrcW-DataW-1:0], item_i.data_byte};
  assign len_bad    = eff_hdr && ((eff_len < HdrMin) || (eff_len > MaxHdr));
  assign adj_len    = eff_hdr ? (eff_len - HdrMin) : eff_len;
  assign crc_next   = crc32_byte(eff_crc, item_i.data_byte);
  assign left_next  = eff_left - LenW'(1);

  // The last prefix byte gives a result only for a corrupt length or an empty payload.
  assign prefix_emit = prefix_end && (len_bad || (adj_len == '0));

  assign produces = !skip && (((eff_phase == PhPrefix) && prefix_emit) ||
                              (eff_phase == PhPayload));
  assign go = item_valid_i && (!produces || !out_valid_q || res_ready_i);
  assign item_take_o = go;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (go) begin
      if (skip) begin
        phase_d = eff_phase;
      end else begin
        unique case (eff_phase)
          PhPrefix: begin
            if (!prefix_end) begin
              phase_d = PhPrefix;
            end else if (len_bad || (adj_len == '0)) begin
              phase_d = PhIdle;
            end else begin
              phase_d = PhPayload;
            end
          end
          PhPayload: phase_d = (left_next == '0) ? PhIdle : PhPayload;
          PhIdle:    phase_d = PhIdle;
          default:   phase_d = PhIdle;
        endcase
      end
    end
  end

  // Chunk registers and the result.
  always_comb begin
    count_d = count_q;
    hdr_d   = hdr_q;
    len_d   = len_q;
    exp_d   = exp_q;
    crc_d   = crc_q;
    left_d  = left_q;
    res_d   = '{payload_byte: '0, payload_valid: 1'b0, last: 1'b0,
                status: StOk, chunk_length: '0};
    if (go) begin
      count_d = eff_count;
      hdr_d   = eff_hdr;
      len_d   = eff_len;
      exp_d   = eff_exp;
      crc_d   = eff_crc;
      left_d  = eff_left;
      if (!skip) begin
        unique case (eff_phase)
          PhPrefix: begin
            if (eff_count < LengthBytes) begin
              len_d = {eff_len[LenW-DataW-1:0], item_i.data_byte};
            end else begin
              exp_d = exp_next;
            end
            count_d = eff_count + CountW'(1);
            if (prefix_end) begin
              count_d = '0;
              if (len_bad) begin
                res_d.last   = 1'b1;
                res_d.status = StCorrupt;
              end else begin
                len_d  = adj_len;
                left_d = adj_len;
                if (adj_len == '0) begin
                  res_d.last = 1'b1;
                  // Empty payload: the CRC of no bytes is zero.
                  if ((exp_next != '0) && (exp_next != ~eff_crc)) begin
                    res_d.status = StCrcFail;
                  end
                end
              end
            end
          end
          PhPayload: begin
            crc_d = crc_next;
            left_d = left_next;
            res_d.payload_byte  = item_i.data_byte;
            res_d.payload_valid = 1'b1;
            if (left_next == '0) begin
              res_d.last = 1'b1;
              res_d.chunk_length = eff_len;
              if ((eff_exp != '0) && (eff_exp != ~crc_next)) begin
                res_d.status = StCrcFail;
              end
            end
          end
          PhIdle: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_d = (go && produces) ? 1'b1 : (res_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      count_q     <= '0;
      hdr_q       <= 1'b0;
      len_q       <= '0;
      exp_q       <= '0;
      crc_q       <= '1;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      hdr_q       <= hdr_d;
      len_q       <= len_d;
      exp_q       <= exp_d;
      crc_q       <= crc_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && produces) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  `BSCD_ASSERT_IMPL(a_payload_has_bytes, phase_q == PhPayload, left_q != '0,
                    "payload phase with no bytes left")
  `BSCD_ASSERT_IMPL(a_count_only_in_prefix, phase_q != PhPrefix, count_q == '0,
                    "prefix count nonzero outside prefix phase")
  `BSCD_ASSERT_IMPL(a_mid_result_plain, out_valid_q && !res_q.last,
                    res_q.payload_valid && (res_q.status == StOk) &&
                    (res_q.chunk_length == '0),
                    "non-final result carries status or length")
  `BSCD_ASSERT_IMPL(a_corrupt_is_final, out_valid_q && (res_q.status == StCorrupt),
                    res_q.last && !res_q.payload_valid && (res_q.chunk_length == '0),
                    "corrupt-length result malformed")
  `BSCD_ASSERT(a_stall_blocks_result,
               !(out_valid_q && !res_ready_i && go && produces),
               "result register overwritten while stalled")
endmodule
`default_nettype wire

// ===== rtl/block_skipping_chunk_deframer_crc32_unit.sv =====
// Top level of the block-skipping chunk deframer with CRC-32 check.
`default_nettype none
// The unit takes one raw file byte per input transaction, tagged with its
// offset inside a storage block and a chunk-start flag. Bytes whose offset is
// a multiple of BLOCK_BYTES are block prefix bytes and are dropped. Of the kept
// bytes of a chunk, the first four are a big-endian length (top bit ignored)
// and the next four a big-endian stored CRC-32; every later byte is payload,
// passed out one per output transaction while a standard CRC-32 runs over it.
// In header mode, sampled on the chunk-start byte, the length must lie between
// 4 and MAX_HEADER, otherwise a single final transaction reports a corrupt
// length; within range, 4 is subtracted. The final transaction of a chunk has
// last set and carries the payload length and the status (ok, corrupt length
// or checksum fail); a stored CRC of zero switches the check off. A new chunk
// start abandons any chunk in progress without a result.
// Throughput is one byte per clock cycle while results are not stalled at the
// output: a byte passes from the input register through the chunk state update
// and the byte-wide CRC step into the result register, which offers the result
// until the receiver takes it.
// A result waiting in the output register does not stop the unit from taking
// bytes that produce no result, and one more byte is held in the input
// register, so the input stalls only while a result cannot be delivered.
module block_skipping_chunk_deframer_crc32_unit #(
  parameter int BLOCK_BYTES = bscd_pkg::BlockBytesDef,
  parameter int MAX_HEADER  = bscd_pkg::MaxHeaderDef
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  bscd_in_if.sink     in_i,
  bscd_out_if.source  out_o
);
  import bscd_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    res_valid;
  result_t res;

  assign in_item = '{data_byte:    in_i.data_byte,
                     block_offset: in_i.block_offset,
                     chunk_start:  in_i.chunk_start,
                     header_mode:  in_i.header_mode};

  bscd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .item_i       (in_item),
    .item_valid_o (held_valid),
    .item_o       (held_item),
    .item_take_i  (take)
  );

  bscd_engine #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_HEADER  (MAX_HEADER)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (held_valid),
    .item_i       (held_item),
    .item_take_o  (take),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (out_o.ready)
  );

  // Result transaction straight from the engine's output register.
  assign out_o.valid         = res_valid;
  assign out_o.payload_byte  = res.payload_byte;
  assign out_o.payload_valid = res.payload_valid;
  assign out_o.last          = res.last;
  assign out_o.status        = res.status;
  assign out_o.chunk_length  = res.chunk_length;
endmodule
`default_nettype wire

// ===== tb/block_skipping_chunk_deframer_crc32_unit_tb.sv =====
// Self-checking testbench for the block-skipping chunk deframer with CRC-32 check.
module block_skipping_chunk_deframer_crc32_unit_tb;
  import bscd_pkg::*;

  // The unit runs with its default geometry: a 4096-byte block, so a 12-bit
  // offset of zero is always a block prefix byte, and a 1024-byte header limit.
  localparam int BlockBytes = BlockBytesDef;
  localparam int MaxHeader  = MaxHeaderDef;
  localparam int RandomItems = 1400;
  // The slowest correct run stays well below this: about 1450 transactions,
  // each waiting out sender gaps and receiver stalls, plus at most a couple
  // of 1020-byte header payloads.
  localparam int CycleLimit = 400000;
  // A byte passes the input and result registers; the drain waits well beyond that.
  localparam int DrainCycles = 20;

  typedef logic [DataW-1:0] byte_q_t[$];

  // Keeps its own copy of the chunk state, predicts the output transactions
  // caused by every accepted input transaction and checks them in order.
  class chunk_checker;
    phase_e          ph;
    logic [CountW-1:0] n_prefix;
    bit              hdr;
    logic [LenW-1:0] len;
    logic [CrcW-1:0] stored_crc;
    logic [CrcW-1:0] crc_reg;
    logic [LenW-1:0] remaining;
    result_t         expected_out_q[$];
    int              n_items, n_results, n_ok, n_corrupt, n_crcfail, errors;

    function new();
      clear_chunk();
    endfunction

    // Reflected CRC-32 over one byte, least significant bit first.
    static function logic [CrcW-1:0] crc_step(logic [CrcW-1:0] crc, logic [DataW-1:0] b);
      logic [CrcW-1:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
        if (c[0]) c = (c >> 1) ^ CrcPoly;
        else c = c >> 1;
      end
      return c;
    endfunction

    function void clear_chunk();
      ph = PhIdle;
      n_prefix = '0;
      hdr = 1'b0;
      len = '0;
      stored_crc = '0;
      crc_reg = '1;
      remaining = '0;
    endfunction

    // A stored CRC of zero switches the check off.
    function status_e end_status();
      if (stored_crc != '0 && stored_crc != ~crc_reg) return StCrcFail;
      return StOk;
    endfunction

    function void push_out(logic [DataW-1:0] b, bit pv, bit lst, status_e st,
                           logic [LenW-1:0] ln);
      result_t r;
      r.payload_byte = b;
      r.payload_valid = pv;
      r.last = lst;
      r.status = st;
      r.chunk_length = ln;
      expected_out_q.push_back(r);
    endfunction

    function void note_byte(item_t it);
      n_items++;
      // A chunk start takes effect even on a skipped prefix byte.
      if (it.chunk_start) begin
        clear_chunk();
        hdr = it.header_mode;
        ph = PhPrefix;
      end
      if (it.block_offset % BlockBytes == 0) return;
      case (ph)
        PhPrefix: begin
          if (n_prefix < LengthBytes) len = {len[LenW-9:0], it.data_byte};
          else stored_crc = {stored_crc[CrcW-9:0], it.data_byte};
          if (n_prefix != LastPrefixByte) begin
            n_prefix++;
            return;
          end
          n_prefix = '0;
          if (hdr) begin
            if (len < HdrMin || len > LenW'(MaxHeader)) begin
              ph = PhIdle;
              push_out('0, 1'b0, 1'b1, StCorrupt, '0);
              return;
            end
            len -= HdrMin;
          end
          if (len == '0) begin
            ph = PhIdle;
            push_out('0, 1'b0, 1'b1, end_status(), '0);
            return;
          end
          remaining = len;
          ph = PhPayload;
        end
        PhPayload: begin
          crc_reg = crc_step(crc_reg, it.data_byte);
          remaining--;
          if (remaining == '0) begin
            ph = PhIdle;
            push_out(it.data_byte, 1'b1, 1'b1, end_status(), len);
          end else begin
            push_out(it.data_byte, 1'b1, 1'b0, StOk, '0);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_output(result_t act);
      result_t exp;
      n_results++;
      if (expected_out_q.size() == 0) begin
        $error("output transaction with nothing expected: byte %0h last %0b",
               act.payload_byte, act.last);
        errors++;
        return;
      end
      exp = expected_out_q.pop_front();
      if (exp.last) begin
        case (exp.status)
          StOk: n_ok++;
          StCorrupt: n_corrupt++;
          default: n_crcfail++;
        endcase
      end
      if (act.payload_byte !== exp.payload_byte) begin
        $error("payload_byte: expected %0h, actual %0h", exp.payload_byte, act.payload_byte);
        errors++;
      end
      if (act.payload_valid !== exp.payload_valid) begin
        $error("payload_valid: expected %0b, actual %0b", exp.payload_valid, act.payload_valid);
        errors++;
      end
      if (act.last !== exp.last) begin
        $error("last: expected %0b, actual %0b", exp.last, act.last);
        errors++;
      end
      if (act.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, act.status);
        errors++;
      end
      if (act.chunk_length !== exp.chunk_length) begin
        $error("chunk_length: expected %0d, actual %0d", exp.chunk_length, act.chunk_length);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cycles;
  chunk_checker sb;

  bscd_in_if  in_if ();
  bscd_out_if out_if ();

  block_skipping_chunk_deframer_crc32_unit #(
    .BLOCK_BYTES(BlockBytes),
    .MAX_HEADER (MaxHeader)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The watchdog ends a run that hangs, whatever the cause.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d output transactions outstanding.",
               cycles, sb.expected_out_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver stalls at random; ready changes only on the falling edge.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every output transaction is sampled on the rising edge at which it is taken.
  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      r.payload_byte = out_if.payload_byte;
      r.payload_valid = out_if.payload_valid;
      r.last = out_if.last;
      r.status = status_e'(out_if.status);
      r.chunk_length = out_if.chunk_length;
      sb.check_output(r);
    end
  end

  // Offers one input transaction after a random gap and holds it until it is
  // accepted. Valid stays high from one transaction to the next when there is
  // no gap, so it is never lowered and raised within one time step.
  task automatic send_raw(input item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= it.data_byte;
    in_if.block_offset <= it.block_offset;
    in_if.chunk_start  <= it.chunk_start;
    in_if.header_mode  <= it.header_mode;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(it);
  endtask

  // Sends a block prefix byte, which the unit drops.
  task automatic send_skipped(input bit start, input bit hmode);
    item_t it;
    it.data_byte = DataW'($urandom);
    it.block_offset = '0;
    it.chunk_start = start;
    it.header_mode = hmode;
    send_raw(it);
  endtask

  // Sends the eight prefix bytes and the body of one chunk, big-endian, with
  // block prefix bytes scattered in between. Only the first keep bytes go
  // out when keep is not negative, which leaves the chunk unfinished.
  task automatic send_chunk(input bit hdr, input logic [31:0] len_field,
                            input logic [31:0] crc_field, input byte_q_t body,
                            input int keep, input int skip_pct, input bit start_on_skip);
    byte_q_t stream;
    item_t   it;
    int      n;
    for (int i = 3; i >= 0; i--) stream.push_back(len_field[8*i +: 8]);
    for (int i = 3; i >= 0; i--) stream.push_back(crc_field[8*i +: 8]);
    foreach (body[i]) stream.push_back(body[i]);
    n = (keep < 0 || keep > stream.size()) ? stream.size() : keep;
    if (start_on_skip) send_skipped(1'b1, hdr);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(99) < skip_pct) send_skipped(1'b0, 1'($urandom));
      it.data_byte = stream[i];
      it.block_offset = OffW'($urandom_range(1, 4095));
      it.chunk_start = (i == 0) && !start_on_skip;
      // Header mode counts only on the start byte, so elsewhere it is noise.
      it.header_mode = it.chunk_start ? hdr : 1'($urandom);
      send_raw(it);
    end
  endtask

  function automatic logic [CrcW-1:0] crc_of(byte_q_t body);
    logic [CrcW-1:0] c;
    c = '1;
    foreach (body[i]) c = chunk_checker::crc_step(c, body[i]);
    return ~c;
  endfunction

  // One random chunk: mostly well formed, sometimes a corrupt header length,
  // an abandoned chunk or loose bytes with every field at random.
  task automatic random_chunk(inout int big_left);
    byte_q_t     body;
    item_t       it;
    int          kind, nbody, crc_mode;
    bit          hdr;
    logic [31:0] len_field, crc_field;
    kind = $urandom_range(99);
    hdr = 1'($urandom);
    nbody = $urandom_range(0, 24);
    if (kind < 70 && big_left > 0 && $urandom_range(199) == 0) begin
      // The longest payload a header chunk can carry.
      hdr = 1'b1;
      nbody = MaxHeader - 4;
      big_left--;
    end
    if (kind >= 70 && kind < 92) nbody = $urandom_range(0, 6);
    for (int i = 0; i < nbody; i++) body.push_back(DataW'($urandom));
    crc_mode = $urandom_range(2);
    crc_field = (crc_mode == 0) ? 32'h0 : (crc_mode == 1) ? crc_of(body) : $urandom;
    // The top bit of the length field is ignored by the unit.
    len_field = {1'($urandom), LenW'(hdr ? nbody + 4 : nbody)};
    if (kind < 70) begin
      send_chunk(hdr, len_field, crc_field, body, -1, $urandom_range(0, 15),
                 $urandom_range(9) == 0);
    end else if (kind < 82) begin
      case ($urandom_range(2))
        0: len_field = $urandom_range(0, 3);
        1: len_field = $urandom_range(MaxHeader + 1, MaxHeader + 80);
        default: len_field = $urandom;
      endcase
      len_field[31] = 1'($urandom);
      send_chunk(1'b1, len_field, crc_field, body, -1, $urandom_range(0, 15), 1'b0);
    end else if (kind < 92) begin
      send_chunk(hdr, $urandom, crc_field, body, $urandom_range(1, 8 + nbody),
                 $urandom_range(0, 15), $urandom_range(9) == 0);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        it.data_byte = DataW'($urandom);
        it.block_offset = OffW'($urandom);
        it.chunk_start = ($urandom_range(7) == 0);
        it.header_mode = 1'($urandom);
        send_raw(it);
      end
    end
  endtask

  initial begin
    byte_q_t body;
    item_t   it;
    int      big_left;
    sb = new();
    cycles = 0;
    big_left = 2;
    send_idle_pct = 28;
    recv_idle_pct = 77;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.block_offset = '0;
    in_if.chunk_start = 1'b0;
    in_if.header_mode = 1'b0;
    out_if.ready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. A kept byte while idle and without a chunk start is
    // ignored; it also carries the largest offset and data value.
    it.data_byte = 8'hFF;
    it.block_offset = 12'hFFF;
    it.chunk_start = 1'b0;
    it.header_mode = 1'b1;
    send_raw(it);
    // A chunk that starts on a skipped prefix byte, with only the masked top
    // bit set in its length: an empty payload with the check switched off.
    body.delete();
    send_chunk(1'b0, 32'h8000_0000, 32'h0, body, -1, 0, 1'b1);
    // A header length below the minimum is reported as corrupt.
    send_chunk(1'b1, 32'd3, 32'h0, body, -1, 0, 1'b0);
    // A header chunk of one zero byte against a wrong stored CRC.
    body.push_back(8'h00);
    send_chunk(1'b1, 32'd5, 32'h1234_5678, body, -1, 0, 1'b0);
    // A chunk abandoned inside its prefix; the random part starts a new one.
    body.delete();
    body.push_back(8'hFF);
    body.push_back(8'h5A);
    send_chunk(1'b0, 32'd2, 32'h0, body, 5, 0, 1'b0);

    // Random part in three idling phases: a slow receiver, then a slow
    // sender, then both at full rate.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 28 : (p == 1) ? 77 : 0;
      recv_idle_pct = (p == 0) ? 77 : (p == 1) ? 28 : 0;
      while (sb.n_items < RandomItems * (p + 1) / 3) random_chunk(big_left);
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // Drain the outstanding results, then give the pipeline time to show any
    // stray output transaction.
    while (sb.expected_out_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d input and %0d output transactions over three idling phases.",
             sb.n_items, sb.n_results);
    $display("Chunk ends: %0d ok, %0d corrupt length, %0d checksum fail.",
             sb.n_ok, sb.n_corrupt, sb.n_crcfail);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
